>>> src/brf_pkg.sv
// Package for the byte ring FIFO: sizes, operation codes and the step result type.
`timescale 1ns / 1ps
package brf_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 8;

  localparam logic [CNT_W-1:0] SIZE_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] SIZE_MAX = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_SKIP  = 2'd3
  } kind_t;

  typedef struct packed {
    logic             accepted;
    logic             is_read;
    logic             do_write;
    logic [CNT_W-1:0] grant;
    logic [IDX_W-1:0] pidx;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] space;
  } step_t;

endpackage

>>> src/byte_ring_fifo_top.sv
// Top level of the byte ring FIFO: slot memory, indices, size register and result register.
// One operation is taken per cycle while the output register is empty or being drained;
// its result appears in the output register on the cycle after acceptance, the read byte
// coming from the slot memory's registered read port.
// A write to ring_size flushes the ring; slot contents are kept.
`timescale 1ns / 1ps
module byte_ring_fifo_top
  import brf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // write_data[7:0], request_length[16:8], zero pad
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // accepted[0], read_data[8:1], granted_length[17:9],
                                      // peek_index[25:18], used_count[34:26],
                                      // space_count[43:35], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data        // ring_size
);

  logic [DATA_W-1:0] slots [0:DEPTH-1];

  logic [CNT_W-1:0]  ring_size;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic [DATA_W-1:0] rd_q;
  step_t             res;
  step_t             out_res;
  logic              out_valid;
  logic              in_xact;
  logic [CNT_W-1:0]  size_clamped;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_xact       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (cfg_data < SIZE_MIN) begin
      size_clamped = SIZE_MIN;
    end else if (cfg_data > SIZE_MAX) begin
      size_clamped = SIZE_MAX;
    end else begin
      size_clamped = cfg_data;
    end
  end

  brf_step u_step (
    .ring_size      (ring_size),
    .head           (head),
    .tail           (tail),
    .kind           (kind_t'(s_axis_tuser)),
    .request_length (s_axis_tdata[16:8]),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (in_xact) begin
      rd_q <= slots[tail];
      if (res.do_write) begin
        slots[head] <= s_axis_tdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= SIZE_MAX;
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ring_size <= size_clamped;
        head      <= '0;
        tail      <= '0;
      end else if (in_xact) begin
        head <= res.head_next;
        tail <= res.tail_next;
      end
      if (in_xact) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xact) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0,
                          out_res.space,
                          out_res.used,
                          out_res.pidx,
                          out_res.grant,
                          (out_res.is_read ? rd_q : {DATA_W{1'b0}}),
                          out_res.accepted};

endmodule

>>> src/brf_step.sv
// Next-state and result logic for one ring operation.
`timescale 1ns / 1ps
module brf_step
  import brf_pkg::*;
(
  input  logic [CNT_W-1:0] ring_size,
  input  logic [IDX_W-1:0] head,
  input  logic [IDX_W-1:0] tail,
  input  kind_t            kind,
  input  logic [CNT_W-1:0] request_length,
  output step_t            res
);

  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] head_inc;
  logic [CNT_W-1:0] tail_adv;
  logic [CNT_W-1:0] used_after;
  logic             empty;

  always_comb begin
    if (head >= tail) begin
      used = CNT_W'(head) - CNT_W'(tail);
    end else begin
      used = ring_size + CNT_W'(head) - CNT_W'(tail);
    end
    empty = (used == '0);
    room = ring_size - CNT_W'(tail);
    len = request_length;
    if (len > used) len = used;
    if (len > room) len = room;
    head_inc = CNT_W'(head) + CNT_W'(1);

    res = '0;
    res.head_next = head;
    res.tail_next = tail;
    used_after = used;
    tail_adv = CNT_W'(tail) + CNT_W'(1);

    unique case (kind)
      KIND_WRITE: begin
        if ((used + CNT_W'(1)) < ring_size) begin
          res.accepted = 1'b1;
          res.do_write = 1'b1;
          res.head_next = (head_inc >= ring_size) ? '0 : head_inc[IDX_W-1:0];
          used_after = used + CNT_W'(1);
        end
      end
      KIND_READ: begin
        if (!empty) begin
          res.accepted = 1'b1;
          res.is_read = 1'b1;
          res.tail_next = (tail_adv >= ring_size) ? '0 : tail_adv[IDX_W-1:0];
          used_after = used - CNT_W'(1);
        end
      end
      KIND_PEEK, KIND_SKIP: begin
        if (!empty) begin
          res.accepted = 1'b1;
          res.grant = len;
          res.pidx = tail;
          if (kind == KIND_SKIP) begin
            tail_adv = CNT_W'(tail) + len;
            res.tail_next = (tail_adv >= ring_size) ? '0 : tail_adv[IDX_W-1:0];
            used_after = used - len;
          end
        end
      end
      default: ;
    endcase

    res.used = used_after;
    res.space = ring_size - CNT_W'(1) - used_after;
  end

endmodule
